[hdl/ppr_pkg.sv]
package ppr_pkg;

  // coefficient store and adjugate
  localparam int NCOEF = 9;
  localparam int CW    = 48;          // coefficient width, Q20.28
  localparam int HW    = CW / 2;      // half width for partial products
  localparam int PW    = 2 * CW;      // full product magnitude width
  localparam int AW    = PW + 1;      // signed adjugate term width

  // datapath widths
  localparam int FPW = CW + 9;        // coefficient times coordinate
  localparam int FW  = FPW + 3;       // forward sum
  localparam int IPW = AW + 9;        // adjugate term times coordinate
  localparam int IW  = IPW + 2;       // inverse sum
  localparam int DW  = 128;           // divider magnitude width
  localparam int QW  = 17;            // quotient bits before saturation
  localparam int NDS = QW + 2;        // S3 stage, range check, one stage per quotient bit

  // work queue
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // source image size
  localparam int SRC_COLS = 256;
  localparam int SRC_ROWS = 128;

  // action codes
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_MAP  = 1'b1;

  typedef logic signed [CW-1:0] coef_t;
  typedef logic signed [AW-1:0] adj_t;

  typedef struct packed {
    logic [7:0] col;
    logic [6:0] row;
  } item_t;

  typedef struct packed {
    logic adj_busy;
    logic back_busy;
  } stat_t;

  // adj[k] = m[A]*m[B] - m[C]*m[D]
  localparam int ADJ_A [NCOEF] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int ADJ_B [NCOEF] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int ADJ_C [NCOEF] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int ADJ_D [NCOEF] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

endpackage

[hdl/ppr_front.sv]
module ppr_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_action,
  input  logic [3:0]          in_coef_index,
  input  logic signed [47:0]  in_coef_value,
  input  logic [7:0]          in_out_col,
  input  logic [6:0]          in_out_row,
  input  ppr_pkg::stat_t      stat,
  output logic                q_valid,
  output ppr_pkg::item_t      q_item,
  input  logic                q_pop,
  output ppr_pkg::coef_t      coef [ppr_pkg::NCOEF],
  output logic                load_start
);

  logic [ppr_pkg::QAW-1:0] wptr_r;
  logic [ppr_pkg::QAW-1:0] rptr_r;
  logic [ppr_pkg::QAW:0]   cnt_r;
  ppr_pkg::item_t          fifo_r [ppr_pkg::QDEPTH];
  ppr_pkg::coef_t          coef_r [ppr_pkg::NCOEF];
  logic                    accept;
  logic                    push;

  // map waits for room and a fresh adjugate; load waits for an empty queue and back end
  assign in_stall = (in_action == ppr_pkg::ACT_MAP) ?
                    ((cnt_r == (ppr_pkg::QAW+1)'(ppr_pkg::QDEPTH)) || stat.adj_busy) :
                    ((cnt_r != '0) || stat.back_busy);

  assign accept     = in_valid && !in_stall;
  assign push       = accept && (in_action == ppr_pkg::ACT_MAP);
  assign load_start = accept && (in_action == ppr_pkg::ACT_LOAD) &&
                      (in_coef_index < 4'(ppr_pkg::NCOEF));

  assign q_valid = (cnt_r != '0);
  assign q_item  = fifo_r[rptr_r];
  assign coef    = coef_r;

  // advance queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (q_pop) rptr_r <= rptr_r + 1'b1;
      cnt_r <= cnt_r + (ppr_pkg::QAW+1)'(push) - (ppr_pkg::QAW+1)'(q_pop);
    end
  end

  // store queue entries and coefficients
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wptr_r] <= '{col: in_out_col, row: in_out_row};
    end
    if (load_start) begin
      coef_r[in_coef_index] <= in_coef_value;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    load_start |=> stat.adj_busy)
    else $error("adjugate not busy after coefficient load");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> cnt_r != '0)
    else $error("pop from empty queue");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_pop) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count lost a push");
`endif

endmodule

[hdl/ppr_adj.sv]
module ppr_adj (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  ppr_pkg::coef_t  coef [ppr_pkg::NCOEF],
  output ppr_pkg::adj_t   adj  [ppr_pkg::NCOEF],
  output logic            busy
);

  logic                      start_r;
  logic [3:0]                iss_r;
  logic [3:0]                wr_r;
  logic                      p_v_r, s_v_r, n_v_r;
  ppr_pkg::coef_t            ch_a_r [ppr_pkg::NCOEF];
  ppr_pkg::coef_t            ch_b_r [ppr_pkg::NCOEF];
  ppr_pkg::coef_t            ch_c_r [ppr_pkg::NCOEF];
  ppr_pkg::coef_t            ch_d_r [ppr_pkg::NCOEF];
  logic [ppr_pkg::CW-1:0]    pab_r [4];
  logic [ppr_pkg::CW-1:0]    pcd_r [4];
  logic                      sab_r, scd_r, sab2_r, scd2_r;
  logic [ppr_pkg::PW-1:0]    mab_r, mcd_r;
  ppr_pkg::adj_t             vab_r, vcd_r;
  ppr_pkg::adj_t             adj_r [ppr_pkg::NCOEF];
  logic [ppr_pkg::CW-1:0]    ma, mb, mc, md;

  function automatic logic [ppr_pkg::CW-1:0] mag48(input ppr_pkg::coef_t v);
    return v[ppr_pkg::CW-1] ? (~v + 1'b1) : v;
  endfunction

  assign ma = mag48(ch_a_r[0]);
  assign mb = mag48(ch_b_r[0]);
  assign mc = mag48(ch_c_r[0]);
  assign md = mag48(ch_d_r[0]);

  assign busy = start_r || (wr_r != '0);
  assign adj  = adj_r;

  // sequence issue and write counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 1'b0;
      iss_r   <= '0;
      wr_r    <= '0;
      p_v_r   <= 1'b0;
      s_v_r   <= 1'b0;
      n_v_r   <= 1'b0;
    end else begin
      start_r <= start;
      if (start_r) begin
        iss_r <= 4'(ppr_pkg::NCOEF);
        wr_r  <= 4'(ppr_pkg::NCOEF);
        p_v_r <= 1'b0;
        s_v_r <= 1'b0;
        n_v_r <= 1'b0;
      end else begin
        p_v_r <= (iss_r != '0);
        if (iss_r != '0) iss_r <= iss_r - 1'b1;
        s_v_r <= p_v_r;
        n_v_r <= s_v_r;
        if (n_v_r) wr_r <= wr_r - 1'b1;
      end
    end
  end

  // load and shift operand chains
  always_ff @(posedge clk) begin
    if (start_r) begin
      for (int k = 0; k < ppr_pkg::NCOEF; k++) begin
        ch_a_r[k] <= coef[ppr_pkg::ADJ_A[k]];
        ch_b_r[k] <= coef[ppr_pkg::ADJ_B[k]];
        ch_c_r[k] <= coef[ppr_pkg::ADJ_C[k]];
        ch_d_r[k] <= coef[ppr_pkg::ADJ_D[k]];
      end
    end else if (iss_r != '0) begin
      for (int k = 0; k < ppr_pkg::NCOEF - 1; k++) begin
        ch_a_r[k] <= ch_a_r[k+1];
        ch_b_r[k] <= ch_b_r[k+1];
        ch_c_r[k] <= ch_c_r[k+1];
        ch_d_r[k] <= ch_d_r[k+1];
      end
    end
  end

  // partial products, sum, sign, difference
  always_ff @(posedge clk) begin
    pab_r[0] <= ma[ppr_pkg::HW +: ppr_pkg::HW] * mb[ppr_pkg::HW +: ppr_pkg::HW];
    pab_r[1] <= ma[ppr_pkg::HW +: ppr_pkg::HW] * mb[0 +: ppr_pkg::HW];
    pab_r[2] <= ma[0 +: ppr_pkg::HW] * mb[ppr_pkg::HW +: ppr_pkg::HW];
    pab_r[3] <= ma[0 +: ppr_pkg::HW] * mb[0 +: ppr_pkg::HW];
    pcd_r[0] <= mc[ppr_pkg::HW +: ppr_pkg::HW] * md[ppr_pkg::HW +: ppr_pkg::HW];
    pcd_r[1] <= mc[ppr_pkg::HW +: ppr_pkg::HW] * md[0 +: ppr_pkg::HW];
    pcd_r[2] <= mc[0 +: ppr_pkg::HW] * md[ppr_pkg::HW +: ppr_pkg::HW];
    pcd_r[3] <= mc[0 +: ppr_pkg::HW] * md[0 +: ppr_pkg::HW];
    sab_r    <= ch_a_r[0][ppr_pkg::CW-1] ^ ch_b_r[0][ppr_pkg::CW-1];
    scd_r    <= ch_c_r[0][ppr_pkg::CW-1] ^ ch_d_r[0][ppr_pkg::CW-1];

    mab_r  <= {pab_r[0], {ppr_pkg::CW{1'b0}}}
            + ((ppr_pkg::PW'(pab_r[1]) + ppr_pkg::PW'(pab_r[2])) << ppr_pkg::HW)
            + ppr_pkg::PW'(pab_r[3]);
    mcd_r  <= {pcd_r[0], {ppr_pkg::CW{1'b0}}}
            + ((ppr_pkg::PW'(pcd_r[1]) + ppr_pkg::PW'(pcd_r[2])) << ppr_pkg::HW)
            + ppr_pkg::PW'(pcd_r[3]);
    sab2_r <= sab_r;
    scd2_r <= scd_r;

    vab_r <= sab2_r ? -$signed(ppr_pkg::AW'(mab_r)) : $signed(ppr_pkg::AW'(mab_r));
    vcd_r <= scd2_r ? -$signed(ppr_pkg::AW'(mcd_r)) : $signed(ppr_pkg::AW'(mcd_r));

    // shift finished terms in from the top
    if (n_v_r) begin
      for (int k = 0; k < ppr_pkg::NCOEF - 1; k++) begin
        adj_r[k] <= adj_r[k+1];
      end
      adj_r[ppr_pkg::NCOEF-1] <= vab_r - vcd_r;
    end
  end

endmodule

[hdl/ppr_back.sv]
module ppr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  ppr_pkg::item_t      q_item,
  output logic                q_pop,
  input  ppr_pkg::coef_t      coef [ppr_pkg::NCOEF],
  input  ppr_pkg::adj_t       adj  [ppr_pkg::NCOEF],
  output logic                back_busy,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_src_col,
  output logic [6:0]          out_src_row,
  output logic                out_src_inside,
  output logic signed [15:0]  out_inv_col,
  output logic signed [15:0]  out_inv_row,
  output logic                out_inv_valid
);

  logic                          adv;
  logic signed [8:0]             c_s, r_s;
  logic                          s1_v_r, s2_v_r;
  logic signed [ppr_pkg::FPW-1:0] s1_fp_r [6];
  logic signed [ppr_pkg::IPW-1:0] s1_ip_r [6];
  logic signed [ppr_pkg::FW-1:0]  s2_fn_r [3];
  logic signed [ppr_pkg::IW-1:0]  s2_in_r [3];

  // divider stages: lanes fwd x, fwd y, inv x, inv y; two denominators
  logic [ppr_pkg::NDS-1:0]   dv_v_r;
  logic [ppr_pkg::DW-1:0]    dv_nm_r  [ppr_pkg::NDS][4];
  logic [ppr_pkg::DW-1:0]    dv_nm_nxt[ppr_pkg::NDS][4];
  logic [ppr_pkg::QW-1:0]    dv_q_r   [ppr_pkg::NDS][4];
  logic [ppr_pkg::QW-1:0]    dv_q_nxt [ppr_pkg::NDS][4];
  logic                      dv_sat_r [ppr_pkg::NDS][4];
  logic                      dv_sat_nxt[ppr_pkg::NDS][4];
  logic                      dv_neg_r [ppr_pkg::NDS][4];
  logic                      dv_neg_nxt[ppr_pkg::NDS][4];
  logic [ppr_pkg::DW-1:0]    dv_dm_r  [ppr_pkg::NDS][2];
  logic [ppr_pkg::DW-1:0]    dv_dm_nxt[ppr_pkg::NDS][2];
  logic                      dv_dz_r  [ppr_pkg::NDS][2];
  logic                      dv_dz_nxt[ppr_pkg::NDS][2];

  logic                      out_v_r;
  logic [7:0]                out_src_col_r;
  logic [6:0]                out_src_row_r;
  logic                      out_src_inside_r;
  logic signed [15:0]        out_inv_col_r, out_inv_row_r;
  logic                      out_inv_valid_r;

  logic [ppr_pkg::QW-1:0]    qx, qy;
  logic                      okx, oky, src_in;
  logic signed [15:0]        ix, iy;

  function automatic logic [ppr_pkg::DW-1:0] mag_f(input logic signed [ppr_pkg::IW-1:0] v);
    logic [ppr_pkg::IW-1:0] a;
    a = v[ppr_pkg::IW-1] ? (~v + 1'b1) : v;
    return ppr_pkg::DW'(a);
  endfunction

  function automatic logic signed [15:0] sat16(input logic [ppr_pkg::QW-1:0] q,
                                                input logic neg);
    if (!neg) return (q > ppr_pkg::QW'(32767)) ? 16'sh7FFF : $signed(q[15:0]);
    return (q >= ppr_pkg::QW'(32768)) ? 16'sh8000 : $signed(-q[15:0]);
  endfunction

  // whole pipe moves unless the result register is held
  assign adv       = !(out_v_r && out_stall);
  assign q_pop     = adv && q_valid;
  assign back_busy = s1_v_r || s2_v_r || (|dv_v_r);

  assign c_s = $signed({1'b0, q_item.col});
  assign r_s = $signed({2'b0, q_item.row});

  // hold control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      dv_v_r  <= '0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= q_valid;
      s2_v_r  <= s1_v_r;
      dv_v_r  <= {dv_v_r[ppr_pkg::NDS-2:0], s2_v_r};
      out_v_r <= dv_v_r[ppr_pkg::NDS-1];
    end
  end

  // products, then row sums
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s1_fp_r[2*k]   <= coef[3*k]   * c_s;
        s1_fp_r[2*k+1] <= coef[3*k+1] * r_s;
        s1_ip_r[2*k]   <= adj[3*k]    * c_s;
        s1_ip_r[2*k+1] <= adj[3*k+1]  * r_s;
        s2_fn_r[k] <= ppr_pkg::FW'(s1_fp_r[2*k]) + ppr_pkg::FW'(s1_fp_r[2*k+1])
                    + ppr_pkg::FW'(coef[3*k+2]);
        s2_in_r[k] <= ppr_pkg::IW'(s1_ip_r[2*k]) + ppr_pkg::IW'(s1_ip_r[2*k+1])
                    + ppr_pkg::IW'(adj[3*k+2]);
      end
    end
  end

  // magnitudes, range check, one quotient bit per stage
  always_comb begin
    dv_nm_nxt[0][0] = mag_f(ppr_pkg::IW'(s2_fn_r[0]));
    dv_nm_nxt[0][1] = mag_f(ppr_pkg::IW'(s2_fn_r[1]));
    dv_nm_nxt[0][2] = mag_f(s2_in_r[0]);
    dv_nm_nxt[0][3] = mag_f(s2_in_r[1]);
    dv_neg_nxt[0][0] = s2_fn_r[0][ppr_pkg::FW-1] ^ s2_fn_r[2][ppr_pkg::FW-1];
    dv_neg_nxt[0][1] = s2_fn_r[1][ppr_pkg::FW-1] ^ s2_fn_r[2][ppr_pkg::FW-1];
    dv_neg_nxt[0][2] = s2_in_r[0][ppr_pkg::IW-1] ^ s2_in_r[2][ppr_pkg::IW-1];
    dv_neg_nxt[0][3] = s2_in_r[1][ppr_pkg::IW-1] ^ s2_in_r[2][ppr_pkg::IW-1];
    dv_dm_nxt[0][0]  = mag_f(ppr_pkg::IW'(s2_fn_r[2]));
    dv_dm_nxt[0][1]  = mag_f(s2_in_r[2]);
    dv_dz_nxt[0][0]  = (s2_fn_r[2] == '0);
    dv_dz_nxt[0][1]  = (s2_in_r[2] == '0);
    for (int l = 0; l < 4; l++) begin
      dv_q_nxt[0][l]   = '0;
      dv_sat_nxt[0][l] = 1'b0;
    end
    for (int s = 1; s < ppr_pkg::NDS; s++) begin
      for (int d = 0; d < 2; d++) begin
        dv_dm_nxt[s][d] = dv_dm_r[s-1][d];
        dv_dz_nxt[s][d] = dv_dz_r[s-1][d];
      end
      for (int l = 0; l < 4; l++) begin
        dv_nm_nxt[s][l]  = dv_nm_r[s-1][l];
        dv_q_nxt[s][l]   = dv_q_r[s-1][l];
        dv_sat_nxt[s][l] = dv_sat_r[s-1][l];
        dv_neg_nxt[s][l] = dv_neg_r[s-1][l];
        if (s == 1) begin
          if (dv_nm_r[0][l] >= (dv_dm_r[0][l>>1] << ppr_pkg::QW)) begin
            dv_sat_nxt[s][l] = 1'b1;
            dv_q_nxt[s][l]   = '1;
          end
        end else if (!dv_sat_r[s-1][l] &&
                     dv_nm_r[s-1][l] >= (dv_dm_r[s-1][l>>1] << (ppr_pkg::NDS-1-s))) begin
          dv_nm_nxt[s][l] = dv_nm_r[s-1][l] - (dv_dm_r[s-1][l>>1] << (ppr_pkg::NDS-1-s));
          dv_q_nxt[s][l]  = dv_q_r[s-1][l] | (ppr_pkg::QW'(1) << (ppr_pkg::NDS-1-s));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_nm_r  <= dv_nm_nxt;
      dv_q_r   <= dv_q_nxt;
      dv_sat_r <= dv_sat_nxt;
      dv_neg_r <= dv_neg_nxt;
      dv_dm_r  <= dv_dm_nxt;
      dv_dz_r  <= dv_dz_nxt;
    end
  end

  // classify forward result, saturate inverse result
  assign qx  = dv_q_r[ppr_pkg::NDS-1][0];
  assign qy  = dv_q_r[ppr_pkg::NDS-1][1];
  assign okx = (qx < ppr_pkg::QW'(ppr_pkg::SRC_COLS)) &&
               (!dv_neg_r[ppr_pkg::NDS-1][0] || (qx == '0));
  assign oky = (qy < ppr_pkg::QW'(ppr_pkg::SRC_ROWS)) &&
               (!dv_neg_r[ppr_pkg::NDS-1][1] || (qy == '0));
  assign src_in = !dv_dz_r[ppr_pkg::NDS-1][0] && okx && oky;
  assign ix = dv_dz_r[ppr_pkg::NDS-1][1] ? 16'sd0 :
              sat16(dv_q_r[ppr_pkg::NDS-1][2], dv_neg_r[ppr_pkg::NDS-1][2]);
  assign iy = dv_dz_r[ppr_pkg::NDS-1][1] ? 16'sd0 :
              sat16(dv_q_r[ppr_pkg::NDS-1][3], dv_neg_r[ppr_pkg::NDS-1][3]);

  always_ff @(posedge clk) begin
    if (adv) begin
      out_src_inside_r <= src_in;
      out_src_col_r    <= src_in ? qx[7:0] : 8'd0;
      out_src_row_r    <= src_in ? qy[6:0] : 7'd0;
      out_inv_col_r    <= ix;
      out_inv_row_r    <= iy;
      out_inv_valid_r  <= !dv_dz_r[ppr_pkg::NDS-1][1] &&
                          (iy < $signed(16'(ppr_pkg::SRC_ROWS)));
    end
  end

  assign out_valid      = out_v_r;
  assign out_src_col    = out_src_col_r;
  assign out_src_row    = out_src_row_r;
  assign out_src_inside = out_src_inside_r;
  assign out_inv_col    = out_inv_col_r;
  assign out_inv_row    = out_inv_row_r;
  assign out_inv_valid  = out_inv_valid_r;

`ifndef NO_ASSERTIONS
  a_black_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_src_inside_r) |-> (out_src_col_r == '0) && (out_src_row_r == '0))
    else $error("black pixel carries nonzero source coordinates");

  a_inv_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_inv_valid_r) |-> out_inv_row_r < $signed(16'(ppr_pkg::SRC_ROWS)))
    else $error("inverse valid with row beyond source height");

  a_inv_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_inv_valid_r && (out_inv_row_r < $signed(16'(ppr_pkg::SRC_ROWS))))
    |-> (out_inv_col_r == 16'sd0) && (out_inv_row_r == 16'sd0))
    else $error("zero inverse denominator with nonzero coordinates");

  a_pop_enters: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> s1_v_r)
    else $error("popped item did not enter the pipe");
`endif

endmodule

[hdl/perspective_pixel_remap_top.sv]
// Channel  Ports                                              Direction
// in       in_valid/in_stall, in_action, in_coef_index,       into block
//          in_coef_value, in_out_col, in_out_row
// out      out_valid/out_stall, out_src_col, out_src_row,     out of block
//          out_src_inside, out_inv_col, out_inv_row, out_inv_valid
//
// Map items enter one per cycle unless a full queue or an adjugate rebuild stalls
// them. The 19 divider stages are magnitudes, range check, one quotient bit each.
// A load is taken once the queue and pipe hold no map item; the adjugate is then
// rebuilt by two 48x48 product units shared across all nine terms; map items wait.
// Reset is synchronous, active low; coefficients stay undefined until loaded.
// A stalled output freezes the whole pipe; the four-entry queue keeps taking
// map items until it fills.
module perspective_pixel_remap_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_action,
  input  logic [3:0]          in_coef_index,
  input  logic signed [47:0]  in_coef_value,
  input  logic [7:0]          in_out_col,
  input  logic [6:0]          in_out_row,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_src_col,
  output logic [6:0]          out_src_row,
  output logic                out_src_inside,
  output logic signed [15:0]  out_inv_col,
  output logic signed [15:0]  out_inv_row,
  output logic                out_inv_valid
);

  ppr_pkg::stat_t  stat;
  ppr_pkg::item_t  q_item;
  ppr_pkg::coef_t  coef [ppr_pkg::NCOEF];
  ppr_pkg::adj_t   adj  [ppr_pkg::NCOEF];
  logic            q_valid, q_pop, load_start, adj_busy, back_busy;

  assign stat = '{adj_busy: adj_busy, back_busy: back_busy};

  ppr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_coef_index (in_coef_index),
    .in_coef_value (in_coef_value),
    .in_out_col    (in_out_col),
    .in_out_row    (in_out_row),
    .stat          (stat),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .coef          (coef),
    .load_start    (load_start)
  );

  ppr_adj u_adj (
    .clk   (clk),
    .rst_n (rst_n),
    .start (load_start),
    .coef  (coef),
    .adj   (adj),
    .busy  (adj_busy)
  );

  ppr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .coef           (coef),
    .adj            (adj),
    .back_busy      (back_busy),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_src_col    (out_src_col),
    .out_src_row    (out_src_row),
    .out_src_inside (out_src_inside),
    .out_inv_col    (out_inv_col),
    .out_inv_row    (out_inv_row),
    .out_inv_valid  (out_inv_valid)
  );

endmodule
